// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sorter RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/isort_pkg.sv -----
// Package for the insertion sorter: widths, default depth, control types.
// Used by the interfaces, the sorting cell and the top level.
package isort_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 16;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sorter_state_t;

  typedef struct packed {
    logic                     ins;
    logic                     shl;
    logic signed [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- rtl/isort_if.sv -----
// Valid/ready channel interfaces for the insertion sorter.
// Depends on isort_pkg for the data width.
interface isort_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [isort_pkg::DATA_W-1:0] value;
  logic                                batch_end;

  modport source (output valid, value, batch_end, input ready);
  modport sink   (input valid, value, batch_end, output ready);
endinterface

interface isort_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [isort_pkg::DATA_W-1:0] sorted_value;
  logic                                run_end;
  logic                                overflow;

  modport source (output valid, sorted_value, run_end, overflow, input ready);
  modport sink   (input valid, sorted_value, run_end, overflow, output ready);
endinterface

// ----- rtl/insertion_sorter.sv -----
// Stable batch sorter for signed 32-bit words, built as a chain of MAX_ELEMENTS
// cells. While a batch fills, one word is taken every cycle and inserted in
// the same cycle by all cells comparing against it at once. The word flagged
// batch_end closes the batch; from the next cycle the chain shifts towards
// its head and delivers one sorted word per accepted output cycle, and no
// input is taken while the chain drains. Words beyond MAX_ELEMENTS are
// dropped and every output word of that batch then has overflow set.
// Depends on isort_pkg, isort_if, isort_cell and assert_macros.svh.
`include "assert_macros.svh"

module insertion_sorter #(
  parameter int MAX_ELEMENTS = isort_pkg::MAX_ELEMENTS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  isort_in_if.sink     in_chan,
  isort_out_if.source  out_chan
);

  localparam int N = MAX_ELEMENTS;

  isort_pkg::sorter_state_t state_r, state_nxt;
  isort_pkg::cell_ctrl_t    ctrl;

  logic                                dropped_r, dropped_nxt;
  logic                                in_acc, out_acc, full;
  logic signed [isort_pkg::DATA_W-1:0] cell_val [N];
  logic                                cell_push [N];
  logic [N-1:0]                        cell_valid;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign full    = cell_valid[N-1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      isort_pkg::ST_FILL: begin
        if (in_acc && in_chan.batch_end) begin
          state_nxt = isort_pkg::ST_DRAIN;
        end
      end
      isort_pkg::ST_DRAIN: begin
        if (out_acc && out_chan.run_end) begin
          state_nxt = isort_pkg::ST_FILL;
        end
      end
      default: state_nxt = isort_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    in_chan.ready  = 1'b0;
    out_chan.valid = 1'b0;
    case (state_r)
      isort_pkg::ST_FILL:  in_chan.ready  = 1'b1;
      isort_pkg::ST_DRAIN: out_chan.valid = 1'b1;
      default: begin
        in_chan.ready  = 1'b0;
        out_chan.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.ins = in_acc && !full;
    ctrl.shl = out_acc;
    ctrl.key = in_chan.value;
  end

  always_comb begin
    dropped_nxt = dropped_r;
    if (out_acc && out_chan.run_end) begin
      dropped_nxt = 1'b0;
    end else if (in_acc && full) begin
      dropped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= isort_pkg::ST_FILL;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                                l_push, l_valid, r_valid;
    logic signed [isort_pkg::DATA_W-1:0] l_val, r_val;

    if (i == 0) begin : g_head
      assign l_push  = 1'b0;
      assign l_valid = 1'b1;
      assign l_val   = '0;
    end else begin : g_body
      assign l_push  = cell_push[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_val   = cell_val[i-1];
    end

    if (i == N-1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_val   = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_val   = cell_val[i+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_push   (l_push),
      .left_valid  (l_valid),
      .left_val    (l_val),
      .right_valid (r_valid),
      .right_val   (r_val),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .push        (cell_push[i])
    );
  end

  assign out_chan.sorted_value = cell_val[0];
  assign out_chan.run_end      = !cell_valid[1];
  assign out_chan.overflow     = dropped_r;

  // The occupied cells always form an unbroken run from the head.
  logic [N:0] valid_run;
  assign valid_run = {1'b0, cell_valid} + {{N{1'b0}}, 1'b1};

  `ASSERT_NOW(a_run_contiguous, 1'b1, $onehot(valid_run),
              "occupied cells are not contiguous from the head")
  `ASSERT_NOW(a_drain_has_word, state_r == isort_pkg::ST_DRAIN, cell_valid[0],
              "draining with an empty head cell")
  `ASSERT_NEXT(a_last_empties, out_acc && out_chan.run_end, cell_valid == '0,
               "store not empty after the last word of a batch")
  `ASSERT_NEXT(a_insert_grows, ctrl.ins, cell_valid != '0,
               "store empty after an insertion")

endmodule

// ----- rtl/isort_cell.sv -----
// One cell of the insertion chain: holds one stored word and its valid bit.
// Depends on isort_pkg for the control struct and the data width.
module isort_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isort_pkg::cell_ctrl_t               ctrl,
  input  logic                                left_push,
  input  logic                                left_valid,
  input  logic signed [isort_pkg::DATA_W-1:0] left_val,
  input  logic                                right_valid,
  input  logic signed [isort_pkg::DATA_W-1:0] right_val,
  output logic signed [isort_pkg::DATA_W-1:0] val,
  output logic                                valid,
  output logic                                push
);

  logic signed [isort_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                                valid_r, valid_nxt;

  // The new word displaces this entry if the entry is empty or strictly larger,
  // so equal words keep their arrival order.
  assign push = !valid_r || ($signed(ctrl.key) < val_r);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.shl) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (ctrl.ins && push) begin
      val_nxt   = left_push ? left_val : ctrl.key;
      valid_nxt = valid_r || left_valid;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule
